// ===== src/xpda_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xpda_pkg: shared definitions for the XOR parity disk array
// Geometry constants, action and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package xpda_pkg;

    localparam int TOTAL_DISKS = 4;
    localparam int DISK_DEPTH  = 1024;
    localparam int DATA_DISKS  = TOTAL_DISKS - 1;
    localparam int DATA_DEPTH  = DATA_DISKS * DISK_DEPTH;

    localparam int ACTION_W    = 2;
    localparam int SEL_W       = 4;
    localparam int POS_W       = 10;
    localparam int BYTE_W      = 8;

    localparam int ADDR_W      = $clog2(DISK_DEPTH);
    localparam int DISK_W      = $clog2(DATA_DISKS);
    localparam int DATA_ADDR_W = $clog2(DATA_DEPTH);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_RAW    = 2'd1,
        ACT_READ   = 2'd2,
        ACT_REPAIR = 2'd3
    } action_t;

    localparam logic STAT_OK       = 1'b0;
    localparam logic STAT_BAD_DISK = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;    // latch the input item
        logic clr_step;   // zero one entry of the stores, advance clear counter
        logic d_first;    // disk counter to 0
        logic d_step;     // disk counter + 1
        logic p_first;    // position counter to 0
        logic p_step;     // position counter + 1
        logic use_pcnt;   // address position from counter, not from item
        logic rd_use_sel; // data read at selected disk, not disk counter
        logic dat_rd;     // data store read
        logic par_rd;     // parity store read
        logic acc_clr;    // accumulator starts from zero with this read
        logic wr_byte;    // data[sel, pos] = byte_in
        logic wr_acc;     // data[sel, pcnt] = acc
        logic par_wr;     // parity[pos] = acc
        logic out_read;   // emit the byte just read
        logic out_ok;     // emit done, byte zero
        logic out_err;    // emit invalid-disk status
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        action_t action;
        logic    data_ok;
        logic    is_parity;
        logic    d_zero;
        logic    d_last;
        logic    d_is_sel;
        logic    p_last;
        logic    clr_last;
    } stat_t;

    // Position reduced modulo DISK_DEPTH, restoring style over constant multiples.
    function automatic logic [ADDR_W-1:0] pos_wrap(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        r = p;
        for (int k = POS_W - 1; k >= 0; k--) begin
            if ((longint'(DISK_DEPTH) << k) <= longint'(r))
                r = r - POS_W'(longint'(DISK_DEPTH) << k);
        end
        return ADDR_W'(r);
    endfunction

endpackage
`default_nettype wire

// ===== src/xpda_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xpda_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module xpda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/xpda_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xpda_datapath: stores, counters, XOR accumulator and result register
// Executes the controller's commands one cycle at a time.
// ----------------------------------------------------------------------------
module xpda_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire xpda_pkg::cmd_t                cmd,
    output xpda_pkg::stat_t                    stat,
    input  wire logic [xpda_pkg::ACTION_W-1:0] action,
    input  wire logic [xpda_pkg::SEL_W-1:0]    disk_sel,
    input  wire logic [xpda_pkg::POS_W-1:0]    position,
    input  wire logic [xpda_pkg::BYTE_W-1:0]   byte_in,
    output logic                               done,
    output logic [xpda_pkg::BYTE_W-1:0]        byte_out,
    output logic                               status
);

    // captured item
    xpda_pkg::action_t                 action_reg;
    logic [xpda_pkg::SEL_W-1:0]        sel_reg;
    logic [xpda_pkg::ADDR_W-1:0]       pos_reg;
    logic [xpda_pkg::BYTE_W-1:0]       byte_reg;

    // counters
    logic [xpda_pkg::DISK_W-1:0]       dcnt_reg;
    logic [xpda_pkg::ADDR_W-1:0]       pcnt_reg;
    logic [xpda_pkg::DATA_ADDR_W-1:0]  clr_reg;

    // accumulator and read-return flags
    logic [xpda_pkg::BYTE_W-1:0]       acc_reg;
    logic [xpda_pkg::BYTE_W-1:0]       acc_next;
    logic                              dat_en_reg;
    logic                              par_en_reg;
    logic                              clr_en_reg;

    // result register
    logic                              done_reg;
    logic [xpda_pkg::BYTE_W-1:0]       byte_out_reg;
    logic                              status_reg;

    // store ports
    logic                              d_we;
    logic [xpda_pkg::DATA_ADDR_W-1:0]  d_waddr;
    logic [xpda_pkg::BYTE_W-1:0]       d_wdata;
    logic [xpda_pkg::DATA_ADDR_W-1:0]  d_raddr;
    logic [xpda_pkg::BYTE_W-1:0]       d_rdata;
    logic                              p_we;
    logic [xpda_pkg::ADDR_W-1:0]       p_waddr;
    logic [xpda_pkg::BYTE_W-1:0]       p_wdata;
    logic [xpda_pkg::ADDR_W-1:0]       p_raddr;
    logic [xpda_pkg::BYTE_W-1:0]       p_rdata;

    logic [xpda_pkg::DISK_W-1:0]       sel_disk;
    logic [xpda_pkg::DISK_W-1:0]       rd_disk;
    logic [xpda_pkg::ADDR_W-1:0]       cur_pos;
    logic                              clr_par;

    function automatic logic [xpda_pkg::DATA_ADDR_W-1:0] cell_addr(
        input logic [xpda_pkg::DISK_W-1:0] d,
        input logic [xpda_pkg::ADDR_W-1:0] p
    );
        return xpda_pkg::DATA_ADDR_W'(d) * xpda_pkg::DATA_ADDR_W'(xpda_pkg::DISK_DEPTH)
               + xpda_pkg::DATA_ADDR_W'(p);
    endfunction

    assign sel_disk = xpda_pkg::DISK_W'(sel_reg);
    assign rd_disk  = cmd.rd_use_sel ? sel_disk : dcnt_reg;
    assign cur_pos  = cmd.use_pcnt ? pcnt_reg : pos_reg;
    assign clr_par  = (32'(clr_reg) < 32'(xpda_pkg::DISK_DEPTH));

    always_comb
    begin
        d_we    = cmd.clr_step | cmd.wr_byte | cmd.wr_acc;
        d_waddr = cmd.clr_step ? clr_reg : cell_addr(sel_disk, cur_pos);
        d_wdata = cmd.clr_step ? '0 : (cmd.wr_acc ? acc_reg : byte_reg);
        d_raddr = cell_addr(rd_disk, cur_pos);
        p_we    = (cmd.clr_step & clr_par) | cmd.par_wr;
        p_waddr = cmd.clr_step ? xpda_pkg::ADDR_W'(clr_reg) : pos_reg;
        p_wdata = cmd.clr_step ? '0 : acc_reg;
        p_raddr = cur_pos;
    end

    xpda_ram #(
        .WIDTH (xpda_pkg::BYTE_W),
        .DEPTH (xpda_pkg::DATA_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (cmd.dat_rd),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    xpda_ram #(
        .WIDTH (xpda_pkg::BYTE_W),
        .DEPTH (xpda_pkg::DISK_DEPTH)
    ) u_parity_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (cmd.par_rd),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    always_comb
    begin
        acc_next = (clr_en_reg ? '0 : acc_reg)
                 ^ (dat_en_reg ? d_rdata : '0)
                 ^ (par_en_reg ? p_rdata : '0);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= xpda_pkg::action_t'(action);
            sel_reg    <= disk_sel;
            pos_reg    <= xpda_pkg::pos_wrap(position);
            byte_reg   <= byte_in;
        end
        if (dat_en_reg | par_en_reg | clr_en_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.d_first)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.d_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.p_first)
        begin
            pcnt_reg <= '0;
        end
        else if (cmd.p_step)
        begin
            pcnt_reg <= pcnt_reg + 1'b1;
        end
        if (cmd.out_read | cmd.out_ok | cmd.out_err)
        begin
            byte_out_reg <= cmd.out_read ? (stat.is_parity ? p_rdata : d_rdata) : '0;
            status_reg   <= cmd.out_err ? xpda_pkg::STAT_BAD_DISK : xpda_pkg::STAT_OK;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            dat_en_reg <= 1'b0;
            par_en_reg <= 1'b0;
            clr_en_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            dat_en_reg <= cmd.dat_rd;
            par_en_reg <= cmd.par_rd;
            clr_en_reg <= cmd.acc_clr;
            done_reg   <= cmd.out_read | cmd.out_ok | cmd.out_err;
        end
    end

    always_comb
    begin
        stat.action    = action_reg;
        stat.data_ok   = (sel_reg < xpda_pkg::SEL_W'(xpda_pkg::DATA_DISKS));
        stat.is_parity = (sel_reg == xpda_pkg::SEL_W'(xpda_pkg::DATA_DISKS));
        stat.d_zero    = (dcnt_reg == '0);
        stat.d_last    = (dcnt_reg == xpda_pkg::DISK_W'(xpda_pkg::DATA_DISKS - 1));
        stat.d_is_sel  = (xpda_pkg::SEL_W'(dcnt_reg) == sel_reg);
        stat.p_last    = (pcnt_reg == xpda_pkg::ADDR_W'(xpda_pkg::DISK_DEPTH - 1));
        stat.clr_last  = (clr_reg == xpda_pkg::DATA_ADDR_W'(xpda_pkg::DATA_DEPTH - 1));
    end

    assign done     = done_reg;
    assign byte_out = byte_out_reg;
    assign status   = status_reg;

endmodule
`default_nettype wire

// ===== src/xpda_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xpda_ctrl: sequencer for the XOR parity disk array
// Clear sweep after reset, then decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
module xpda_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    output xpda_pkg::cmd_t       cmd,
    input  wire xpda_pkg::stat_t stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_WT,
        S_PX_RD,
        S_PX_WT,
        S_PX_WR,
        S_RP_RD,
        S_RP_WT,
        S_RP_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.d_first = 1'b1;
                cmd.p_first = 1'b1;
                unique case (stat.action)
                    xpda_pkg::ACT_WRITE:
                    begin
                        if (stat.data_ok)
                        begin
                            cmd.wr_byte = 1'b1;
                            cmd.acc_clr = 1'b1;
                            state_next  = S_PX_RD;
                        end
                        else
                        begin
                            cmd.out_err = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    xpda_pkg::ACT_RAW:
                    begin
                        if (stat.data_ok)
                        begin
                            cmd.wr_byte = 1'b1;
                            cmd.out_ok  = 1'b1;
                        end
                        else
                        begin
                            cmd.out_err = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    xpda_pkg::ACT_READ:
                    begin
                        if (stat.data_ok)
                        begin
                            cmd.dat_rd     = 1'b1;
                            cmd.rd_use_sel = 1'b1;
                            state_next     = S_RD_WT;
                        end
                        else if (stat.is_parity)
                        begin
                            cmd.par_rd = 1'b1;
                            state_next = S_RD_WT;
                        end
                        else
                        begin
                            cmd.out_err = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    xpda_pkg::ACT_REPAIR:
                    begin
                        if (stat.data_ok)
                        begin
                            state_next = S_RP_RD;
                        end
                        else
                        begin
                            cmd.out_err = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.out_err = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_RD_WT:
            begin
                cmd.out_read = 1'b1;
                state_next   = S_IDLE;
            end
            S_PX_RD:
            begin
                cmd.dat_rd = 1'b1;
                cmd.d_step = 1'b1;
                if (stat.d_last)
                begin
                    state_next = S_PX_WT;
                end
            end
            S_PX_WT:
            begin
                state_next = S_PX_WR;
            end
            S_PX_WR:
            begin
                cmd.par_wr = 1'b1;
                cmd.out_ok = 1'b1;
                state_next = S_IDLE;
            end
            S_RP_RD:
            begin
                cmd.use_pcnt = 1'b1;
                cmd.dat_rd   = !stat.d_is_sel;
                cmd.par_rd   = stat.d_zero;
                cmd.acc_clr  = stat.d_zero;
                cmd.d_step   = 1'b1;
                if (stat.d_last)
                begin
                    state_next = S_RP_WT;
                end
            end
            S_RP_WT:
            begin
                state_next = S_RP_WR;
            end
            S_RP_WR:
            begin
                cmd.use_pcnt = 1'b1;
                cmd.wr_acc   = 1'b1;
                cmd.p_step   = 1'b1;
                cmd.d_first  = 1'b1;
                if (stat.p_last)
                begin
                    cmd.out_ok = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ===== src/xor_parity_disk_array_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xor_parity_disk_array_top: byte-wide data disks plus one XOR parity disk
// Checked write, raw write, byte read and full-disk repair over block RAM.
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken at
// that edge. Exactly one result follows: done is high for one cycle with
// byte_out and status valid, and there is no way to hold it off, so the
// receiver must sample it then. After reset the block sweeps both stores to
// zero, one data entry per cycle, over all DATA_DISKS*DISK_DEPTH data entries
// (3072 at the default geometry), and holds busy high meanwhile. A checked
// write reads the data disks one per cycle through the single read port of
// the data RAM to rebuild parity; a repair steps every position through the
// data disks, reading each one but the selected disk through that port along
// with the parity byte, then writes back. A new item may be taken in the
// same cycle done is shown.
// ----------------------------------------------------------------------------
module xor_parity_disk_array_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [xpda_pkg::ACTION_W-1:0] action,
    input  wire logic [xpda_pkg::SEL_W-1:0]    disk_sel,
    input  wire logic [xpda_pkg::POS_W-1:0]    position,
    input  wire logic [xpda_pkg::BYTE_W-1:0]   byte_in,
    output logic                               done,
    output logic [xpda_pkg::BYTE_W-1:0]        byte_out,
    output logic                               status
);

    xpda_pkg::cmd_t  cmd;   // sequencer commands, one set per cycle
    xpda_pkg::stat_t stat;  // decoded item and counter flags back to sequencer

    // Controller: clear sweep, decode, per-action step sequences.
    xpda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Datapath: data and parity RAMs, XOR accumulator, result register.
    xpda_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .action   (action),
        .disk_sel (disk_sel),
        .position (position),
        .byte_in  (byte_in),
        .done     (done),
        .byte_out (byte_out),
        .status   (status)
    );

endmodule
`default_nettype wire

// ===== src/xpda_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xpda_checker: port-level checks for the XOR parity disk array
// Bound to the top level; watches the command and result ports only.
// ----------------------------------------------------------------------------
module xpda_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [xpda_pkg::ACTION_W-1:0] action,
    input wire logic [xpda_pkg::SEL_W-1:0]    disk_sel,
    input wire logic                          done,
    input wire logic [xpda_pkg::BYTE_W-1:0]   byte_out,
    input wire logic                          status
);

    // an accepted item keeps the block busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // results are never shown in two consecutive cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    // error results carry a zero byte
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (byte_out == '0))
        else $error("nonzero byte with error status");

    // bad disk on checked or raw write or repair yields an error result
    a_bad_disk: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action != xpda_pkg::ACT_READ) &&
         (disk_sel >= xpda_pkg::SEL_W'(xpda_pkg::DATA_DISKS)))
        |=> ##1 (done && status))
        else $error("invalid disk not reported");

endmodule

bind xor_parity_disk_array_top xpda_checker u_xpda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .disk_sel (disk_sel),
    .done     (done),
    .byte_out (byte_out),
    .status   (status)
);
`default_nettype wire
